>>> hdl/vivf_pkg.sv
// Shared constants, codes and state type for the isolated voxel filter.
package vivf_pkg;

    localparam int MAX_SIZE_DEF   = 256;
    localparam int MAX_RADIUS_DEF = 3;

    localparam int CFG_W      = 9;
    localparam int CFG_ADDR_W = 2;
    localparam int RAD_W      = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SIZE_Z = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS = 2'd3;

    localparam logic [CFG_W-1:0] SIZE_RST   = 9'd256;
    localparam logic [RAD_W-1:0] RADIUS_RST = 2'd1;

    localparam logic REQ_VOXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN
    } vivf_state_t;

endpackage

>>> hdl/vivf_window_mem.sv
// Plane window memory: one row of voxel bits per entry, one write and one registered read.
module vivf_window_mem #(
    parameter int MAX_SIZE   = vivf_pkg::MAX_SIZE_DEF,
    parameter int NUM_PLANES = 2 * vivf_pkg::MAX_RADIUS_DEF + 2
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [$clog2(NUM_PLANES)-1:0] wr_slot,
    input  logic [$clog2(MAX_SIZE)-1:0]   wr_row,
    input  logic [MAX_SIZE-1:0]           wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(NUM_PLANES)-1:0] rd_slot,
    input  logic [$clog2(MAX_SIZE)-1:0]   rd_row,
    output logic [MAX_SIZE-1:0]           rd_data
);

    logic [MAX_SIZE-1:0] mem [NUM_PLANES][MAX_SIZE];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_slot][wr_row] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_slot][rd_row];
        end
    end

endmodule

>>> hdl/volume_isolated_voxel_filter.sv
// Top level of the isolated voxel filter: counters, neighborhood scan and result register.
//
// Voxels arrive one beat at a time in raster order (x fastest, then y, then z) and are
// written, a whole row at a time, into a window memory that holds the last
// 2*MAX_RADIUS+2 z-planes. After each input beat the block checks whether the cube
// around the oldest undecided voxel has fully arrived; if so it reads the cube's rows
// one per cycle from the window memory and issues one result beat with the voxel's
// coordinates and a keep flag. No input beat is taken until the check, and any scan
// that follows, is done; the single read port of the window memory is why the rows
// are read one at a time. A finished result waits in the output register while the
// next beat is taken. Flush beats (tuser high) carry no voxel and only drain pending
// decisions; once the last decision of a volume is out, the counters restart for
// the next volume. The window memory has no reset.
module volume_isolated_voxel_filter #(
    parameter int MAX_SIZE   = vivf_pkg::MAX_SIZE_DEF,
    parameter int MAX_RADIUS = vivf_pkg::MAX_RADIUS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // config write port
    input  logic                            cfg_wr_en,
    input  logic [vivf_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [vivf_pkg::CFG_W-1:0]      cfg_wdata,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [0] voxel_set
    input  logic                            s_tuser,   // [0] req_type
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata    // [7:0] pos_x, [15:8] pos_y,
                                                       // [23:16] pos_z, [24] keep
);

    localparam int NUM_PLANES = 2 * MAX_RADIUS + 2;
    localparam int CW = $clog2(MAX_SIZE + 1);   // coordinate that may reach the size
    localparam int XW = $clog2(MAX_SIZE);       // index into a row or the row count
    localparam int SW = $clog2(NUM_PLANES);
    localparam int RW = $clog2(MAX_RADIUS + 1);

    // configuration registers
    logic [vivf_pkg::CFG_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [vivf_pkg::RAD_W-1:0] radius_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= vivf_pkg::SIZE_RST;
            size_y_reg <= vivf_pkg::SIZE_RST;
            size_z_reg <= vivf_pkg::SIZE_RST;
            radius_reg <= vivf_pkg::RADIUS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                vivf_pkg::CFG_SIZE_X: size_x_reg <= cfg_wdata;
                vivf_pkg::CFG_SIZE_Y: size_y_reg <= cfg_wdata;
                vivf_pkg::CFG_SIZE_Z: size_z_reg <= cfg_wdata;
                vivf_pkg::CFG_RADIUS: radius_reg <= cfg_wdata[vivf_pkg::RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // effective sizes: zero acts as one, oversize clamps to MAX_SIZE
    logic [CW-1:0] sx, sy, sz;
    logic [RW-1:0] rad;

    always_comb begin
        int ex, ey, ez, er;
        ex = int'(size_x_reg);
        ey = int'(size_y_reg);
        ez = int'(size_z_reg);
        er = int'(radius_reg);
        if (ex == 0) ex = 1;
        if (ex > MAX_SIZE) ex = MAX_SIZE;
        if (ey == 0) ey = 1;
        if (ey > MAX_SIZE) ey = MAX_SIZE;
        if (ez == 0) ez = 1;
        if (ez > MAX_SIZE) ez = MAX_SIZE;
        if (er > MAX_RADIUS) er = MAX_RADIUS;
        sx  = CW'(ex);
        sy  = CW'(ey);
        sz  = CW'(ez);
        rad = RW'(er);
    end

    // state
    vivf_pkg::vivf_state_t state_reg, state_next;

    logic [CW-1:0]       in_x_reg, in_y_reg, in_z_reg, in_x_next, in_y_next, in_z_next;
    logic [SW-1:0]       in_slot_reg, in_slot_next;
    logic [CW-1:0]       out_x_reg, out_y_reg, out_z_reg, out_x_next, out_y_next, out_z_next;
    logic [SW-1:0]       out_slot_reg, out_slot_next;
    logic [MAX_SIZE-1:0] row_reg, row_next;

    logic [CW-1:0]       sj_reg, sj_next, sk_reg, sk_next;
    logic [CW-1:0]       y0_reg, y0_next, y1_reg, y1_next, z1_reg, z1_next;
    logic [SW-1:0]       sslot_reg, sslot_next;
    logic [MAX_SIZE-1:0] mask_reg, mask_next;
    logic                rd_vld_reg, rd_vld_next, rd_ctr_reg, rd_ctr_next;
    logic                any_reg, any_next, ctr_bit_reg, ctr_bit_next;

    logic                out_valid_reg, out_valid_next;
    logic [31:0]         out_data_reg, out_data_next;

    // memory port
    logic                wr_en, rd_en;
    logic [MAX_SIZE-1:0] rd_data;

    vivf_window_mem #(
        .MAX_SIZE   (MAX_SIZE),
        .NUM_PLANES (NUM_PLANES)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_slot (in_slot_reg),
        .wr_row  (in_y_reg[XW-1:0]),
        .wr_data (row_next),
        .rd_en   (rd_en),
        .rd_slot (sslot_reg),
        .rd_row  (sj_reg[XW-1:0]),
        .rd_data (rd_data)
    );

    logic accept, in_done, out_free, dec_ready, scan_last;
    logic [CW-1:0] nx, ny, nz;

    assign accept   = s_tvalid && s_tready;
    assign in_done  = (in_z_reg >= sz);
    assign out_free = !out_valid_reg || m_tready;
    assign scan_last = (sj_reg == y1_reg) && (sk_reg == z1_reg);

    // last voxel of the oldest pending cube
    always_comb begin
        int tx, ty, tz;
        tx = int'(out_x_reg) + int'(rad);
        ty = int'(out_y_reg) + int'(rad);
        tz = int'(out_z_reg) + int'(rad);
        if (tx > int'(sx) - 1) tx = int'(sx) - 1;
        if (ty > int'(sy) - 1) ty = int'(sy) - 1;
        if (tz > int'(sz) - 1) tz = int'(sz) - 1;
        nx = CW'(tx);
        ny = CW'(ty);
        nz = CW'(tz);
    end

    assign dec_ready = in_done || (nz < in_z_reg) ||
                       (nz == in_z_reg && (ny < in_y_reg ||
                                           (ny == in_y_reg && nx < in_x_reg)));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            vivf_pkg::ST_IDLE:  if (accept) state_next = vivf_pkg::ST_CHECK;
            vivf_pkg::ST_CHECK: begin
                if (!dec_ready) begin
                    state_next = vivf_pkg::ST_IDLE;
                end else if (out_free) begin
                    state_next = vivf_pkg::ST_SCAN;
                end
            end
            vivf_pkg::ST_SCAN:  if (scan_last) state_next = vivf_pkg::ST_DRAIN;
            vivf_pkg::ST_DRAIN: state_next = vivf_pkg::ST_IDLE;
            default:            state_next = vivf_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        int x0, x1, y0, z0, zoff, sl;
        logic restart, hit, keep;
        logic [MAX_SIZE-1:0] sel;

        s_tready = (state_reg == vivf_pkg::ST_IDLE);
        wr_en    = 1'b0;
        rd_en    = 1'b0;

        in_x_next = in_x_reg;  in_y_next = in_y_reg;  in_z_next = in_z_reg;
        in_slot_next = in_slot_reg;
        out_x_next = out_x_reg;  out_y_next = out_y_reg;  out_z_next = out_z_reg;
        out_slot_next = out_slot_reg;
        row_next   = row_reg;
        sj_next = sj_reg;  sk_next = sk_reg;
        y0_next = y0_reg;  y1_next = y1_reg;  z1_next = z1_reg;
        sslot_next = sslot_reg;
        mask_next  = mask_reg;
        rd_vld_next = 1'b0;
        rd_ctr_next = 1'b0;
        any_next = any_reg;
        ctr_bit_next = ctr_bit_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        x0 = 0; x1 = 0; y0 = 0; z0 = 0; zoff = 0; sl = 0;
        restart = 1'b0; hit = 1'b0; keep = 1'b0;
        sel = '0;

        // fold in the row read last cycle; the center voxel itself does not count
        if (rd_vld_reg) begin
            sel = rd_data & mask_reg;
            if (rd_ctr_reg) begin
                ctr_bit_next = rd_data[out_x_reg[XW-1:0]];
                sel[out_x_reg[XW-1:0]] = 1'b0;
            end
            hit = |sel;
            any_next = any_reg || hit;
        end

        case (state_reg)
            vivf_pkg::ST_IDLE: begin
                if (accept) begin
                    // restart when sizes shrank below the decisions already issued
                    restart = (out_z_reg >= sz);
                    if (restart) begin
                        in_x_next = '0;  in_y_next = '0;  in_z_next = '0;
                        in_slot_next = '0;
                        out_x_next = '0; out_y_next = '0; out_z_next = '0;
                        out_slot_next = '0;
                    end
                    if (s_tuser == vivf_pkg::REQ_VOXEL && (restart || !in_done)) begin
                        wr_en = 1'b0;
                        if (!restart) begin
                            wr_en = 1'b1;
                            row_next = (in_x_reg == '0) ? '0 : row_reg;
                            row_next[in_x_reg[XW-1:0]] = s_tdata[0];
                            // advance raster position
                            if (in_x_reg + 1'b1 == sx) begin
                                in_x_next = '0;
                                if (in_y_reg + 1'b1 == sy) begin
                                    in_y_next = '0;
                                    in_z_next = in_z_reg + 1'b1;
                                    in_slot_next = (int'(in_slot_reg) + 1 == NUM_PLANES) ?
                                                   '0 : in_slot_reg + 1'b1;
                                end else begin
                                    in_y_next = in_y_reg + 1'b1;
                                end
                            end else begin
                                in_x_next = in_x_reg + 1'b1;
                            end
                        end
                    end
                end
            end
            vivf_pkg::ST_CHECK: begin
                if (dec_ready && out_free) begin
                    x0 = (int'(out_x_reg) > int'(rad)) ? int'(out_x_reg) - int'(rad) : 0;
                    y0 = (int'(out_y_reg) > int'(rad)) ? int'(out_y_reg) - int'(rad) : 0;
                    z0 = (int'(out_z_reg) > int'(rad)) ? int'(out_z_reg) - int'(rad) : 0;
                    x1 = int'(nx);
                    zoff = int'(out_z_reg) - z0;
                    sl = (int'(out_slot_reg) >= zoff) ? int'(out_slot_reg) - zoff :
                         int'(out_slot_reg) + NUM_PLANES - zoff;
                    for (int i = 0; i < MAX_SIZE; i++) begin
                        mask_next[i] = (i >= x0) && (i <= x1);
                    end
                    y0_next = CW'(y0);
                    y1_next = ny;
                    z1_next = nz;
                    sj_next = CW'(y0);
                    sk_next = CW'(z0);
                    sslot_next = SW'(sl);
                    any_next = 1'b0;
                    ctr_bit_next = 1'b0;
                end
            end
            vivf_pkg::ST_SCAN: begin
                rd_en = 1'b1;
                rd_vld_next = 1'b1;
                rd_ctr_next = (sj_reg == out_y_reg) && (sk_reg == out_z_reg);
                if (sj_reg == y1_reg) begin
                    sj_next = y0_reg;
                    sk_next = sk_reg + 1'b1;
                    sslot_next = (int'(sslot_reg) + 1 == NUM_PLANES) ?
                                 '0 : sslot_reg + 1'b1;
                end else begin
                    sj_next = sj_reg + 1'b1;
                end
            end
            vivf_pkg::ST_DRAIN: begin
                keep = ctr_bit_next && any_next;
                out_valid_next = 1'b1;
                out_data_next  = {7'd0, keep, 8'(out_z_reg), 8'(out_y_reg), 8'(out_x_reg)};
                // advance decision position, restart after the last voxel of the volume
                if (out_x_reg + 1'b1 == sx) begin
                    out_x_next = '0;
                    if (out_y_reg + 1'b1 == sy) begin
                        out_y_next = '0;
                        if (out_z_reg + 1'b1 == sz) begin
                            out_z_next = '0;  out_slot_next = '0;
                            in_x_next = '0;   in_y_next = '0;  in_z_next = '0;
                            in_slot_next = '0;
                        end else begin
                            out_z_next = out_z_reg + 1'b1;
                            out_slot_next = (int'(out_slot_reg) + 1 == NUM_PLANES) ?
                                            '0 : out_slot_reg + 1'b1;
                        end
                    end else begin
                        out_y_next = out_y_reg + 1'b1;
                    end
                end else begin
                    out_x_next = out_x_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= vivf_pkg::ST_IDLE;
            in_x_reg      <= '0;
            in_y_reg      <= '0;
            in_z_reg      <= '0;
            in_slot_reg   <= '0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_z_reg     <= '0;
            out_slot_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            rd_ctr_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            in_x_reg      <= in_x_next;
            in_y_reg      <= in_y_next;
            in_z_reg      <= in_z_next;
            in_slot_reg   <= in_slot_next;
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_z_reg     <= out_z_next;
            out_slot_reg  <= out_slot_next;
            rd_vld_reg    <= rd_vld_next;
            rd_ctr_reg    <= rd_ctr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        row_reg      <= row_next;
        sj_reg       <= sj_next;
        sk_reg       <= sk_next;
        y0_reg       <= y0_next;
        y1_reg       <= y1_next;
        z1_reg       <= z1_next;
        sslot_reg    <= sslot_next;
        mask_reg     <= mask_next;
        any_reg      <= any_next;
        ctr_bit_reg  <= ctr_bit_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> hdl/vivf_checker.sv
// Port-level checks for the isolated voxel filter, bound to the top level.
module vivf_port_assertions (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // one input beat at a time
    a_in_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    // results come no faster than one per input beat
    a_out_spaced: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("back-to-back results");

    // spare bits of the result stay zero
    a_out_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:25] == 7'd0)
        else $error("nonzero padding in result");

endmodule

bind volume_isolated_voxel_filter vivf_port_assertions u_vivf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> sim/vivf_checker.sv
// Checker for the isolated voxel filter: predicts every decision and compares result beats.
module vivf_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [vivf_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [vivf_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [0] voxel_set
    input  logic                            s_tuser,   // [0] req_type
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [31:0]                     m_tdata,   // [7:0] pos_x, [15:8] pos_y,
                                                       // [23:16] pos_z, [24] keep
    input  logic                            end_check,
    output int                              fail_count,
    output int                              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PLANES = 2 * vivf_pkg::MAX_RADIUS_DEF + 2;

    typedef struct packed {
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] pos_z;
        logic       keep;
    } decision_t;

    decision_t   decision_q[$];
    bit          voxel_mem[0:PLANES-1][0:vivf_pkg::MAX_SIZE_DEF-1][0:vivf_pkg::MAX_SIZE_DEF-1];
    int unsigned voxels_in;
    int unsigned decided;
    logic [vivf_pkg::CFG_W-1:0] reg_sx, reg_sy, reg_sz;
    logic [vivf_pkg::RAD_W-1:0] reg_rad;

    function automatic int unsigned clamp_dim(input logic [vivf_pkg::CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > vivf_pkg::MAX_SIZE_DEF) return vivf_pkg::MAX_SIZE_DEF;
        return 32'(v);
    endfunction

    function automatic int unsigned min_u(input int unsigned a, input int unsigned b);
        return (a > b) ? b : a;
    endfunction

    // True when the voxel is set and any other voxel of its clipped cube is set.
    function automatic bit voxel_kept(input int unsigned x, input int unsigned y,
                                      input int unsigned z, input int unsigned sx,
                                      input int unsigned sy, input int unsigned sz,
                                      input int unsigned r);
        int unsigned x0, x1, y0, y1, z0, z1;
        if (!voxel_mem[z % PLANES][y][x]) return 0;
        x0 = (x > r) ? x - r : 0;
        y0 = (y > r) ? y - r : 0;
        z0 = (z > r) ? z - r : 0;
        x1 = min_u(x + r, sx - 1);
        y1 = min_u(y + r, sy - 1);
        z1 = min_u(z + r, sz - 1);
        for (int unsigned k = z0; k <= z1; k++)
            for (int unsigned j = y0; j <= y1; j++)
                for (int unsigned i = x0; i <= x1; i++) begin
                    if (i == x && j == y && k == z) continue;
                    if (voxel_mem[k % PLANES][j][i]) return 1;
                end
        return 0;
    endfunction

    task automatic predict_beat(input logic req, input logic set);
        int unsigned sx, sy, sz, r, plane, total, x, y, z, need;
        decision_t d;
        sx = clamp_dim(reg_sx);
        sy = clamp_dim(reg_sy);
        sz = clamp_dim(reg_sz);
        r = (reg_rad > vivf_pkg::MAX_RADIUS_DEF) ? vivf_pkg::MAX_RADIUS_DEF : 32'(reg_rad);
        plane = sx * sy;
        total = plane * sz;
        if (decided >= total) begin
            voxels_in = 0;
            decided = 0;
        end
        // store the voxel; beats past the end of the volume act as flushes
        if (req == vivf_pkg::REQ_VOXEL && voxels_in < total) begin
            voxel_mem[(voxels_in / plane) % PLANES][(voxels_in / sx) % sy][voxels_in % sx]
                = set;
            voxels_in++;
        end
        x = decided % sx;
        y = (decided / sx) % sy;
        z = decided / plane;
        need = min_u(z + r, sz - 1) * plane + min_u(y + r, sy - 1) * sx + min_u(x + r, sx - 1);
        if (voxels_in < total && need >= voxels_in) return;
        d.pos_x = x[7:0];
        d.pos_y = y[7:0];
        d.pos_z = z[7:0];
        d.keep  = voxel_kept(x, y, z, sx, sy, sz, r);
        decision_q.push_back(d);
        decided++;
        if (decided >= total) begin
            voxels_in = 0;
            decided = 0;
        end
    endtask

    always @(posedge aclk) begin
        decision_t want;
        if (!aresetn) begin
            voxels_in = 0;
            decided = 0;
            reg_sx = vivf_pkg::SIZE_RST;
            reg_sy = vivf_pkg::SIZE_RST;
            reg_sz = vivf_pkg::SIZE_RST;
            reg_rad = vivf_pkg::RADIUS_RST;
            decision_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    vivf_pkg::CFG_SIZE_X: reg_sx = cfg_wdata;
                    vivf_pkg::CFG_SIZE_Y: reg_sy = cfg_wdata;
                    vivf_pkg::CFG_SIZE_Z: reg_sz = cfg_wdata;
                    vivf_pkg::CFG_RADIUS: reg_rad = cfg_wdata[vivf_pkg::RAD_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_beat(s_tuser, s_tdata[0]);
            if (m_tvalid && m_tready) begin
                if (decision_q.size() == 0) begin
                    $error("result beat with no decision pending: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = decision_q.pop_front();
                    if (m_tdata[7:0] !== want.pos_x) begin
                        $error("pos_x expected %0d actual %0d", want.pos_x, m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tdata[15:8] !== want.pos_y) begin
                        $error("pos_y expected %0d actual %0d", want.pos_y, m_tdata[15:8]);
                        fail_count++;
                    end
                    if (m_tdata[23:16] !== want.pos_z) begin
                        $error("pos_z expected %0d actual %0d", want.pos_z, m_tdata[23:16]);
                        fail_count++;
                    end
                    if (m_tdata[24] !== want.keep) begin
                        $error("keep expected %0d actual %0d", want.keep, m_tdata[24]);
                        fail_count++;
                    end
                end
            end
            if (end_check && decision_q.size() != 0) begin
                $error("%0d decisions never came out", decision_q.size());
                fail_count++;
            end
        end
        outstanding = decision_q.size();
    end

endmodule

>>> sim/volume_isolated_voxel_filter_tb.sv
// Testbench top for the isolated voxel filter: stimulus, stalls, timeout and verdict.
module volume_isolated_voxel_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_VOXELS = 700;
    localparam int SETTLE = 60;   // wait after each volume; covers the longest decision

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [vivf_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [vivf_pkg::CFG_W-1:0]      cfg_wdata;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [7:0]                      s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [31:0]                     m_tdata;
    logic                            end_check;
    int                              fail_count;
    int                              outstanding;

    int  cycles;
    int  results_seen;
    int  voxel_beats;
    bit  calm;   // when set, both sides run without gaps

    volume_isolated_voxel_filter DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    vivf_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .end_check(end_check), .fail_count(fail_count), .outstanding(outstanding)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Watchdog: stop a hung run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[volume_isolated_voxel_filter] ERROR");
            $finish;
        end
    end

    // Count result beats so the drain loop knows when a volume is done.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) results_seen <= results_seen + 1;
    end

    // Flip between stalled and gap-free stretches now and then.
    initial begin
        forever begin
            repeat ($urandom_range(100, 600)) @(posedge aclk);
            calm = ~calm;
        end
    end

    // Result side: stall a random number of cycles before each beat.
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Push one input beat after a random gap; hold valid if the next beat follows at once.
    task automatic send_beat(input logic req, input logic set);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'd0, set};
        do @(posedge aclk); while (!s_tready);
        if (req == vivf_pkg::REQ_VOXEL) voxel_beats++;
    endtask

    function automatic int clamp_dim(input int v);
        if (v == 0) return 1;
        if (v > vivf_pkg::MAX_SIZE_DEF) return vivf_pkg::MAX_SIZE_DEF;
        return v;
    endfunction

    // Write all four registers back to back, then drop the enable.
    task automatic set_volume(input int sx, input int sy, input int sz, input int r);
        logic [vivf_pkg::CFG_W-1:0] vals[4];
        logic [vivf_pkg::CFG_ADDR_W-1:0] idx[4];
        vals = '{sx[vivf_pkg::CFG_W-1:0], sy[vivf_pkg::CFG_W-1:0],
                 sz[vivf_pkg::CFG_W-1:0], r[vivf_pkg::CFG_W-1:0]};
        idx  = '{vivf_pkg::CFG_SIZE_X, vivf_pkg::CFG_SIZE_Y,
                 vivf_pkg::CFG_SIZE_Z, vivf_pkg::CFG_RADIUS};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Stream one whole volume, then drain it with flush beats until every decision is out.
    task automatic run_volume(input int sx, input int sy, input int sz, input int r,
                              input int density);
        int total;
        int target;
        total  = clamp_dim(sx) * clamp_dim(sy) * clamp_dim(sz);
        target = results_seen + total;
        set_volume(sx, sy, sz, r);
        for (int i = 0; i < total; i++) begin
            // stray flush mid-volume: usually drains nothing
            if ($urandom_range(0, 11) == 0)
                send_beat(vivf_pkg::REQ_FLUSH, 1'($urandom_range(0, 1)));
            send_beat(vivf_pkg::REQ_VOXEL, $urandom_range(0, 99) < density);
        end
        // The last voxel is still undecided here, so a voxel beat only acts as a flush.
        if (r >= 1 && total >= 2 && $urandom_range(0, 1))
            send_beat(vivf_pkg::REQ_VOXEL, 1'($urandom_range(0, 1)));
        while (results_seen < target)
            send_beat(vivf_pkg::REQ_FLUSH, 1'($urandom_range(0, 1)));
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin
        int sx, sy, sz;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = vivf_pkg::REQ_VOXEL;
        end_check = 1'b0;
        voxel_beats = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: lone voxel, zero size acting as one, radius extremes, empty and full.
        run_volume(1, 1, 1, 1, 100);
        run_volume(0, 2, 3, 0, 100);
        run_volume(2, 2, 2, 3, 100);
        run_volume(3, 1, 1, 2, 0);
        run_volume(3, 1, 1, 1, 50);

        // Random volumes: mostly tiny, a few with one axis at or beyond the maximum.
        voxel_beats = 0;
        while (voxel_beats < RANDOM_VOXELS) begin
            if ($urandom_range(0, 9) == 0) begin
                sx = $urandom_range(0, 1);
                sy = $urandom_range(0, 1);
                sz = $urandom_range(0, 1);
                case ($urandom_range(0, 2))
                    0: sx = $urandom_range(0, 1) ? 256 : $urandom_range(257, 511);
                    1: sy = $urandom_range(0, 1) ? 256 : $urandom_range(257, 511);
                    default: sz = $urandom_range(0, 1) ? 256 : $urandom_range(257, 511);
                endcase
            end else begin
                sx = $urandom_range(0, 6);
                sy = $urandom_range(1, 6);
                sz = $urandom_range(1, 6);
            end
            run_volume(sx, sy, sz, $urandom_range(0, 3), $urandom_range(0, 4) * 25);
        end

        end_check <= 1'b1;
        @(posedge aclk);
        end_check <= 1'b0;
        @(posedge aclk);
        if (fail_count == 0) begin
            $display("[volume_isolated_voxel_filter] OK");
        end else begin
            $display("[volume_isolated_voxel_filter] ERROR");
        end
        $finish;
    end

endmodule
